### rtl/fir_ps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fir_ps_pkg
// Shared widths, request and register codes, and divider status type for the
// per-tap scaled FIR filter.
// ----------------------------------------------------------------------------
package fir_ps_pkg;

    // Default sizing
    localparam int MAX_TAPS_DEF     = 32;
    localparam int SAMPLE_WIDTH_DEF = 16;

    // Fixed field widths
    localparam int COEF_W    = 32;
    localparam int OUT_W     = 32;
    localparam int SCALE_W   = 31;
    localparam int TAPS_W    = 6;
    localparam int TAP_IDX_W = 5;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = SCALE_W;

    // Default product width (coefficient times sample)
    localparam int PROD_W_DEF = COEF_W + SAMPLE_WIDTH_DEF;

    // Request codes
    localparam logic REQ_FILTER = 1'b0;
    localparam logic REQ_COEF   = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAPS  = 1'b1;

    // Reset values
    localparam logic [SCALE_W-1:0] SCALE_RST = SCALE_W'(1);
    localparam logic [TAPS_W-1:0]  TAPS_RST  = TAPS_W'(32);

    // Divider status seen by the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage : fir_ps_pkg
`default_nettype wire

### rtl/fir_filter_per_tap_scaled.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fir_filter_per_tap_scaled
// Direct-form FIR over a circular delay line, each tap product divided by a
// programmable scale before accumulation.
// ----------------------------------------------------------------------------
// A coefficient item (req_type 1) writes one tap and gives no result. A
// sample item (req_type 0) stores the sample, walks the n active taps one at
// a time through a single multiplier and a shared bit-serial divider, and
// gives one result; the divider, at one quotient bit per cycle, sets the time
// that it takes. in_stall is high while a sample item is in work; a finished
// result waits in the output register while the next item is taken. The
// delay line reads as zero after reset through per-entry valid bits;
// coefficients must be written before use.
// ----------------------------------------------------------------------------
module fir_filter_per_tap_scaled
    import fir_ps_pkg::*;
#(
    parameter int MAX_TAPS     = MAX_TAPS_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // configuration
    input  wire logic                           cfg_wr_en,
    input  wire logic        [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic        [CFG_W-1:0]        cfg_data,
    // input items
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic                           req_type,
    input  wire logic        [TAP_IDX_W-1:0]    tap_index,
    input  wire logic signed [COEF_W-1:0]       coefficient_value,
    input  wire logic signed [SAMPLE_WIDTH-1:0] sample_value,
    // result items
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic signed [OUT_W-1:0]             filter_output
);

    localparam int PTR_W  = $clog2(MAX_TAPS);
    localparam int CNT_W  = $clog2(MAX_TAPS + 1);
    localparam int PROD_W = COEF_W + SAMPLE_WIDTH;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_MUL,
        S_DIV,
        S_WAIT,
        S_PUSH
    } state_t;

    // Control and datapath registers
    state_t                    state_reg,    state_next;
    logic [SCALE_W-1:0]        scale_reg,    scale_next;
    logic [TAPS_W-1:0]         taps_reg,     taps_next;
    logic [PTR_W-1:0]          wp_reg,       wp_next;
    logic [MAX_TAPS-1:0]       vld_reg,      vld_next;
    logic [CNT_W-1:0]          n_reg,        n_next;
    logic [PTR_W-1:0]          i_reg,        i_next;
    logic [PTR_W-1:0]          k_reg,        k_next;
    logic                      samp_vld_reg, samp_vld_next;
    logic signed [PROD_W-1:0]  prod_reg,     prod_next;
    logic [OUT_W-1:0]          acc_reg,      acc_next;
    logic                      out_vld_reg,  out_vld_next;
    logic [OUT_W-1:0]          out_dat_reg,  out_dat_next;

    // Memories and their registered read data
    logic signed [COEF_W-1:0]       coef_mem  [MAX_TAPS];
    logic signed [SAMPLE_WIDTH-1:0] delay_mem [MAX_TAPS];
    logic signed [COEF_W-1:0]       coef_rd_reg;
    logic signed [SAMPLE_WIDTH-1:0] samp_rd_reg;
    logic signed [SAMPLE_WIDTH-1:0] samp_op;

    // Strobes
    logic                 accept;
    logic                 coef_wr;
    logic                 samp_wr;
    logic                 rd_en;
    logic                 div_start;
    logic                 tap_ok;
    logic [PTR_W-1:0]     coef_addr;
    logic [CNT_W-1:0]     n_cur;
    logic [PTR_W-1:0]     p_cur;
    logic [CNT_W-1:0]     p_inc;
    logic                 last_tap;
    logic [OUT_W-1:0]     div_quot;
    div_status_t          div_st;

    // Active taps: zero acts as one, above depth saturates
    always_comb
    begin
        if (taps_reg == '0)
            n_cur = CNT_W'(1);
        else if (32'(taps_reg) > 32'(MAX_TAPS))
            n_cur = CNT_W'(MAX_TAPS);
        else
            n_cur = CNT_W'(taps_reg);
    end

    // Pointer wraps to zero if the ring shrank under it
    assign p_cur     = (CNT_W'(wp_reg) >= n_cur) ? '0 : wp_reg;
    assign p_inc     = CNT_W'(p_cur) + CNT_W'(1);
    assign tap_ok    = (32'(tap_index) < 32'(MAX_TAPS));
    assign coef_addr = PTR_W'(tap_index);
    assign last_tap  = ((CNT_W'(i_reg) + CNT_W'(1)) == n_reg);
    assign samp_op   = samp_vld_reg ? samp_rd_reg : '0;

    assign accept    = in_valid && (state_reg == S_IDLE);
    assign coef_wr   = accept && (req_type == REQ_COEF) && tap_ok;
    assign samp_wr   = accept && (req_type == REQ_FILTER);
    assign rd_en     = (state_reg == S_READ);
    assign div_start = (state_reg == S_DIV);

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        scale_next    = scale_reg;
        taps_next     = taps_reg;
        wp_next       = wp_reg;
        vld_next      = vld_reg;
        n_next        = n_reg;
        i_next        = i_reg;
        k_next        = k_reg;
        samp_vld_next = samp_vld_reg;
        prod_next     = prod_reg;
        acc_next      = acc_reg;
        out_vld_next  = out_vld_reg;
        out_dat_next  = out_dat_reg;

        // configuration writes
        if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_SCALE: scale_next = cfg_data[SCALE_W-1:0];
                CFG_TAPS:  taps_next  = cfg_data[TAPS_W-1:0];
                default:   ;
            endcase
        end

        // result taken downstream
        if (out_vld_reg && !out_stall)
            out_vld_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (samp_wr)
                begin
                    vld_next[p_cur] = 1'b1;
                    wp_next    = (p_inc >= n_cur) ? '0 : PTR_W'(p_inc);
                    n_next     = n_cur;
                    i_next     = '0;
                    k_next     = p_cur;
                    acc_next   = '0;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                samp_vld_next = vld_reg[k_reg];
                state_next    = S_MUL;
            end
            S_MUL:
            begin
                prod_next  = PROD_W'(coef_rd_reg) * PROD_W'(samp_op);
                state_next = S_DIV;
            end
            S_DIV:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (div_st.done)
                begin
                    acc_next = acc_reg + div_quot;
                    if (last_tap)
                        state_next = S_PUSH;
                    else
                    begin
                        i_next     = i_reg + PTR_W'(1);
                        k_next     = (k_reg == '0) ? PTR_W'(n_reg - CNT_W'(1))
                                                   : k_reg - PTR_W'(1);
                        state_next = S_READ;
                    end
                end
            end
            S_PUSH:
            begin
                if (!out_vld_reg || !out_stall)
                begin
                    out_vld_next = 1'b1;
                    out_dat_next = acc_reg;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            scale_reg    <= SCALE_RST;
            taps_reg     <= TAPS_RST;
            wp_reg       <= '0;
            vld_reg      <= '0;
            n_reg        <= CNT_W'(1);
            i_reg        <= '0;
            k_reg        <= '0;
            samp_vld_reg <= 1'b0;
            prod_reg     <= '0;
            acc_reg      <= '0;
            out_vld_reg  <= 1'b0;
            out_dat_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            scale_reg    <= scale_next;
            taps_reg     <= taps_next;
            wp_reg       <= wp_next;
            vld_reg      <= vld_next;
            n_reg        <= n_next;
            i_reg        <= i_next;
            k_reg        <= k_next;
            samp_vld_reg <= samp_vld_next;
            prod_reg     <= prod_next;
            acc_reg      <= acc_next;
            out_vld_reg  <= out_vld_next;
            out_dat_reg  <= out_dat_next;
        end
    end

    // Coefficient and delay-line memories, registered reads
    always_ff @(posedge clk)
    begin
        if (coef_wr)
            coef_mem[coef_addr] <= coefficient_value;
        if (samp_wr)
            delay_mem[p_cur] <= sample_value;
        if (rd_en)
        begin
            coef_rd_reg <= coef_mem[i_reg];
            samp_rd_reg <= delay_mem[k_reg];
        end
    end

    // Shared divider
    fir_ps_div #(
        .DIVIDEND_W (PROD_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (scale_reg),
        .quotient (div_quot),
        .status   (div_st)
    );

    assign in_stall      = (state_reg != S_IDLE);
    assign out_valid     = out_vld_reg;
    assign filter_output = out_dat_reg;

endmodule : fir_filter_per_tap_scaled
`default_nettype wire

### rtl/fir_ps_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fir_ps_div
// Shared radix-2 restoring divider: signed dividend over positive divisor,
// quotient truncated toward zero, low 32 bits returned. One bit per cycle.
// ----------------------------------------------------------------------------
module fir_ps_div
    import fir_ps_pkg::*;
#(
    parameter int DIVIDEND_W = PROD_W_DEF
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic signed [DIVIDEND_W-1:0] dividend,
    input  wire logic        [SCALE_W-1:0]    divisor,
    output logic             [OUT_W-1:0]      quotient,
    output div_status_t                       status
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg,  busy_next;
    logic                  done_reg,  done_next;
    logic [CNT_W-1:0]      cnt_reg,   cnt_next;
    logic                  neg_reg,   neg_next;
    logic [DIVIDEND_W-1:0] mag_reg,   mag_next;   // dividend in, quotient out
    logic [SCALE_W-1:0]    rem_reg,   rem_next;
    logic [SCALE_W-1:0]    dvs_reg,   dvs_next;

    logic [SCALE_W:0]      rem_shift;
    logic [SCALE_W:0]      rem_diff;
    logic                  q_bit;
    logic [OUT_W-1:0]      q_low;

    // One restoring step: shift in next dividend bit, trial subtract
    assign rem_shift = {rem_reg, mag_reg[DIVIDEND_W-1]};
    assign rem_diff  = rem_shift - {1'b0, dvs_reg};
    assign q_bit     = (rem_shift >= {1'b0, dvs_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        mag_next  = mag_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIVIDEND_W);
            neg_next  = dividend[DIVIDEND_W-1];
            mag_next  = dividend[DIVIDEND_W-1] ? (~dividend + DIVIDEND_W'(1))
                                               : dividend;
            rem_next  = '0;
            // divisor of zero acts as one
            dvs_next  = (divisor == '0) ? SCALE_W'(1) : divisor;
        end
        else if (busy_reg)
        begin
            mag_next = {mag_reg[DIVIDEND_W-2:0], q_bit};
            rem_next = q_bit ? rem_diff[SCALE_W-1:0] : rem_shift[SCALE_W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            neg_reg  <= 1'b0;
            mag_reg  <= '0;
            rem_reg  <= '0;
            dvs_reg  <= SCALE_W'(1);
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            neg_reg  <= neg_next;
            mag_reg  <= mag_next;
            rem_reg  <= rem_next;
            dvs_reg  <= dvs_next;
        end
    end

    // Restore sign on the low word of the quotient
    assign q_low       = mag_reg[OUT_W-1:0];
    assign quotient    = neg_reg ? (~q_low + OUT_W'(1)) : q_low;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule : fir_ps_div
`default_nettype wire

### rtl/fir_ps_chk.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fir_ps_chk
// Port-level checks on the FIR filter: handshake hold on results and
// busy/ready behavior per item kind.
// ----------------------------------------------------------------------------
module fir_ps_chk
    import fir_ps_pkg::*;
(
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           in_valid,
    input wire logic                           in_stall,
    input wire logic                           req_type,
    input wire logic                           out_valid,
    input wire logic                           out_stall,
    input wire logic signed [OUT_W-1:0]        filter_output
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(filter_output))
        else $error("result changed while stalled");

    // Coefficient items leave the block ready again in the following cycle
    a_coef_fast: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (req_type == REQ_COEF) |=> !in_stall)
        else $error("not ready after coefficient write");

    // Sample items occupy the block
    a_samp_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (req_type == REQ_FILTER) |=> in_stall)
        else $error("ready right after sample item");

    // A new result appears only at the end of a sample's work
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without sample work");

endmodule : fir_ps_chk

bind fir_filter_per_tap_scaled fir_ps_chk u_fir_ps_chk (.*);
`default_nettype wire
